// File: hdl/lgs_pkg.sv
// Shared types, codes and constants for the life grid generation step block.
package lgs_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int FUNC_W    = 2;
	localparam int COORD_W   = 6;
	localparam int NCNT_W    = 4;

	localparam logic [CFG_W-1:0]  GRID_RESET = 7'd64;
	localparam logic [NCNT_W-1:0] LIVE_LOW   = 4'd2;
	localparam logic [NCNT_W-1:0] LIVE_HIGH  = 4'd3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SET   = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_STEP  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MODIFY,
		ST_LOAD1,
		ST_ROW,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_ITEM,
		RD_CNT,
		RD_CNT1,
		RD_CNT2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ZERO,
		WR_SET,
		WR_STEP
	} wr_sel_t;

	typedef struct packed {
		logic    take_item;
		logic    cnt_inc;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    win_load;
		logic    win_shift;
		logic    alive_load;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              in_range;
		logic              grid_empty;
		logic              last_row;
		logic              last_clear;
		logic              out_free;
	} status_t;

endpackage

// File: hdl/lgs_ifs.sv
// Valid/ready channel interfaces for request and response words.
interface lgs_req_if;
	logic                        valid;
	logic                        ready;
	logic [lgs_pkg::FUNC_W-1:0]  func;
	logic [lgs_pkg::COORD_W-1:0] col;
	logic [lgs_pkg::COORD_W-1:0] row;

	modport source (output valid, output func, output col, output row, input ready);
	modport sink   (input valid, input func, input col, input row, output ready);
endinterface

interface lgs_rsp_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic out_of_range;

	modport source (output valid, output cell_alive, output out_of_range, input ready);
	modport sink   (input valid, input cell_alive, input out_of_range, output ready);
endinterface

// File: hdl/lgs_ctrl.sv
// Controller state machine: sequences clear sweep, set/query and generation step.
module lgs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lgs_pkg::status_t st,
	output lgs_pkg::cmd_t    cmd
);

	lgs_pkg::state_t state_q, state_nxt;
	logic            is_sq;

	assign is_sq = (st.func == lgs_pkg::FUNC_SET) || (st.func == lgs_pkg::FUNC_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lgs_pkg::ST_CLEAR: begin
				if (st.last_clear) state_nxt = lgs_pkg::ST_IDLE;
			end
			lgs_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = lgs_pkg::ST_DECODE;
			end
			lgs_pkg::ST_DECODE: begin
				if (is_sq && st.in_range) begin
					state_nxt = lgs_pkg::ST_MODIFY;
				end else if (st.func == lgs_pkg::FUNC_STEP && !st.grid_empty) begin
					state_nxt = lgs_pkg::ST_LOAD1;
				end else begin
					state_nxt = lgs_pkg::ST_DONE;
				end
			end
			lgs_pkg::ST_MODIFY: state_nxt = lgs_pkg::ST_DONE;
			lgs_pkg::ST_LOAD1:  state_nxt = lgs_pkg::ST_ROW;
			lgs_pkg::ST_ROW: begin
				if (st.last_row) state_nxt = lgs_pkg::ST_DONE;
			end
			lgs_pkg::ST_DONE: begin
				if (st.out_free) state_nxt = lgs_pkg::ST_IDLE;
			end
			default: state_nxt = lgs_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = lgs_pkg::RD_NONE;
		cmd.wr_sel = lgs_pkg::WR_NONE;
		req_ready  = 1'b0;
		case (state_q)
			lgs_pkg::ST_CLEAR: begin
				cmd.wr_sel  = lgs_pkg::WR_ZERO;
				cmd.cnt_inc = !st.last_clear;
			end
			lgs_pkg::ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.take_item = req_valid;
			end
			lgs_pkg::ST_DECODE: begin
				if (is_sq && st.in_range) begin
					cmd.rd_sel = lgs_pkg::RD_ITEM;
				end else if (st.func == lgs_pkg::FUNC_STEP && !st.grid_empty) begin
					cmd.rd_sel = lgs_pkg::RD_CNT;
				end
			end
			lgs_pkg::ST_MODIFY: begin
				if (st.func == lgs_pkg::FUNC_SET) begin
					cmd.wr_sel = lgs_pkg::WR_SET;
				end else begin
					cmd.alive_load = 1'b1;
				end
			end
			lgs_pkg::ST_LOAD1: begin
				cmd.win_load = 1'b1;
				cmd.rd_sel   = lgs_pkg::RD_CNT1;
			end
			lgs_pkg::ST_ROW: begin
				// write back row r while row r+2 is fetched
				cmd.win_shift = 1'b1;
				cmd.wr_sel    = lgs_pkg::WR_STEP;
				cmd.rd_sel    = lgs_pkg::RD_CNT2;
				cmd.cnt_inc   = !st.last_row;
			end
			lgs_pkg::ST_DONE: begin
				cmd.res_load = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_res_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> st.out_free)
		else $error("result loaded while response register still held");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lgs_pkg::ST_CLEAR |=> state_q != lgs_pkg::ST_CLEAR)
		else $error("clear sweep re-entered after reset");

endmodule

// File: hdl/lgs_dp.sv
// Datapath: config registers, row-wide cell memory, row window with neighbor lanes, response.
module lgs_dp #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [lgs_pkg::FUNC_W-1:0]     req_func,
	input  logic [lgs_pkg::COORD_W-1:0]    req_col,
	input  logic [lgs_pkg::COORD_W-1:0]    req_row,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic                           rsp_cell_alive,
	output logic                           rsp_out_of_range,
	input  lgs_pkg::cmd_t                  cmd,
	output lgs_pkg::status_t               st
);

	localparam int RAW = $clog2(MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int HW  = (lgs_pkg::CFG_W > RAW + 2) ? lgs_pkg::CFG_W : RAW + 2;
	localparam int WW  = (lgs_pkg::CFG_W > CW + 1) ? lgs_pkg::CFG_W : CW + 1;
	localparam int NW  = lgs_pkg::NCNT_W;

	logic [lgs_pkg::CFG_W-1:0]   grid_width_q, grid_height_q;
	logic [WW-1:0]               used_w;
	logic [HW-1:0]               used_h;
	logic [lgs_pkg::FUNC_W-1:0]  func_q;
	logic [lgs_pkg::COORD_W-1:0] col_q, row_q;
	logic [RAW-1:0]              cnt_q;
	logic [HW-1:0]               cnt_ext, cnt1, cnt2;
	logic                        in_range, nxt_ok;
	logic [CW-1:0]               col_idx;

	logic [MAX_WIDTH-1:0] mem_q [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] rd_q;
	logic                 rd_en, wr_en;
	logic [RAW-1:0]       rd_addr, wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;

	logic [MAX_WIDTH-1:0] prev_q, cur_q;
	logic [MAX_WIDTH-1:0] col_mask, p_m, c_m, n_m, new_row, step_row, set_row;
	logic [MAX_WIDTH+1:0] p_pad, c_pad, n_pad;
	logic [NW-1:0]        nb [MAX_WIDTH];

	logic res_alive_q, rsp_valid_q, rsp_alive_q, rsp_oor_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lgs_pkg::GRID_RESET;
			grid_height_q <= lgs_pkg::GRID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lgs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				lgs_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sizes above the maximum saturate
	assign used_w = (WW'(grid_width_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_width_q);
	assign used_h = (HW'(grid_height_q) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
		: HW'(grid_height_q);

	// captured word
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			func_q <= req_func;
			col_q  <= req_col;
			row_q  <= req_row;
		end
	end

	assign in_range = (WW'(col_q) < used_w) && (HW'(row_q) < used_h);
	assign col_idx  = CW'(col_q);

	// row counter: clear sweep and step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.take_item) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt1[RAW-1:0];
		end
	end

	assign cnt_ext = HW'(cnt_q);
	assign cnt1    = cnt_ext + HW'(1);
	assign cnt2    = cnt_ext + HW'(2);
	assign nxt_ok  = cnt1 < used_h;

	// cell memory, one row a word
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = cnt_q;
		case (cmd.rd_sel)
			lgs_pkg::RD_ITEM: rd_addr = RAW'(row_q);
			lgs_pkg::RD_CNT:  rd_addr = cnt_q;
			lgs_pkg::RD_CNT1: rd_addr = cnt1[RAW-1:0];
			lgs_pkg::RD_CNT2: rd_addr = cnt2[RAW-1:0];
			default:          rd_en   = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = cnt_q;
		wr_data = step_row;
		case (cmd.wr_sel)
			lgs_pkg::WR_ZERO: wr_data = '0;
			lgs_pkg::WR_SET: begin
				wr_addr = RAW'(row_q);
				wr_data = set_row;
			end
			lgs_pkg::WR_STEP: wr_data = step_row;
			default:          wr_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_comb begin
		set_row          = rd_q;
		set_row[col_idx] = 1'b1;
	end

	// three-row window of the old generation
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			prev_q <= '0;
			cur_q  <= rd_q;
		end else if (cmd.win_shift) begin
			prev_q <= cur_q;
			cur_q  <= rd_q;
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			col_mask[j] = WW'(j) < used_w;
		end
	end

	// columns past the grid edge count as dead
	assign p_m   = prev_q & col_mask;
	assign c_m   = cur_q & col_mask;
	assign n_m   = nxt_ok ? (rd_q & col_mask) : '0;
	assign p_pad = {1'b0, p_m, 1'b0};
	assign c_pad = {1'b0, c_m, 1'b0};
	assign n_pad = {1'b0, n_m, 1'b0};

	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			nb[j] = NW'(p_pad[j]) + NW'(p_pad[j+1]) + NW'(p_pad[j+2])
				+ NW'(c_pad[j]) + NW'(c_pad[j+2])
				+ NW'(n_pad[j]) + NW'(n_pad[j+1]) + NW'(n_pad[j+2]);
			if (c_m[j]) begin
				new_row[j] = nb[j] inside {[lgs_pkg::LIVE_LOW:lgs_pkg::LIVE_HIGH]};
			end else begin
				new_row[j] = nb[j] == lgs_pkg::LIVE_HIGH;
			end
		end
	end

	// cells beyond the width in use keep their value
	assign step_row = (new_row & col_mask) | (cur_q & ~col_mask);

	// result and response register
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			res_alive_q <= 1'b0;
		end else if (cmd.alive_load) begin
			res_alive_q <= rd_q[col_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_alive_q <= res_alive_q;
			rsp_oor_q   <= ((func_q == lgs_pkg::FUNC_SET) || (func_q == lgs_pkg::FUNC_QUERY))
				&& !in_range;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_cell_alive   = rsp_alive_q;
	assign rsp_out_of_range = rsp_oor_q;

	assign st.func       = func_q;
	assign st.in_range   = in_range;
	assign st.grid_empty = (used_w == '0) || (used_h == '0);
	assign st.last_row   = cnt1 >= used_h;
	assign st.last_clear = cnt_q == RAW'(MAX_HEIGHT - 1);
	assign st.out_free   = !rsp_valid_q || rsp_ready;

	a_item_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_sel == lgs_pkg::RD_ITEM |-> in_range)
		else $error("cell row read for an out-of-range coordinate");

	a_step_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_sel == lgs_pkg::WR_STEP |-> (cnt_ext < used_h) && (used_w != '0))
		else $error("step write-back outside the grid in use");

endmodule

// File: hdl/life_grid_generation_step_top.sv
// Top level of the life grid generation step block (B3/S23, non-wrapping grid).
// Set and query: the row is read, then written back with the cell set, or sampled; the
// response is registered once the response register is free. Step: every row in use, up
// to grid_height capped at MAX_HEIGHT, is rewritten, one memory row read and written per cycle.
// Unused func code, out-of-range set/query, step on empty grid: response with no memory access.
// Reset: config to 64 x 64, then a clear pass over all MAX_HEIGHT rows with req.ready low.
module life_grid_generation_step_top #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata,
	lgs_req_if.sink                       req,
	lgs_rsp_if.source                     rsp
);

	lgs_pkg::cmd_t    cmd;
	lgs_pkg::status_t st;

	lgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	lgs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_func         (req.func),
		.req_col          (req.col),
		.req_row          (req.row),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_cell_alive   (rsp.cell_alive),
		.rsp_out_of_range (rsp.out_of_range),
		.cmd              (cmd),
		.st               (st)
	);

endmodule

// File: tb/life_grid_generation_step_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the life grid block: set, query and generation step words.

typedef struct packed {
	logic cell_alive;
	logic out_of_range;
} life_result_t;

class life_scoreboard;
	bit           cells[lgs_pkg::MAX_HEIGHT_DEF][lgs_pkg::MAX_WIDTH_DEF];
	logic [6:0]   width_reg;
	logic [6:0]   height_reg;
	life_result_t pending_q[$];
	int           errors;
	int           checked;

	function new();
		foreach (cells[r, c]) cells[r][c] = 1'b0;
		width_reg  = lgs_pkg::GRID_RESET;
		height_reg = lgs_pkg::GRID_RESET;
		errors     = 0;
		checked    = 0;
	endfunction

	function void write_reg(lgs_pkg::reg_idx_t idx, logic [6:0] v);
		if (idx == lgs_pkg::REG_GRID_WIDTH)
			width_reg = v;
		else
			height_reg = v;
	endfunction

	// sizes above the array bound saturate
	function int used(logic [6:0] v, int limit);
		return (v > limit) ? limit : int'(v);
	endfunction

	function void advance_generation();
		int uw;
		int uh;
		int n;
		int counts[lgs_pkg::MAX_HEIGHT_DEF][lgs_pkg::MAX_WIDTH_DEF];
		uw = used(width_reg, lgs_pkg::MAX_WIDTH_DEF);
		uh = used(height_reg, lgs_pkg::MAX_HEIGHT_DEF);
		// all counts from the old generation first; cells past the edge count as dead
		for (int r = 0; r < uh; r++)
			for (int c = 0; c < uw; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < uh &&
						    c + dc >= 0 && c + dc < uw)
							n += cells[r + dr][c + dc];
				counts[r][c] = n;
			end
		for (int r = 0; r < uh; r++)
			for (int c = 0; c < uw; c++)
				if (cells[r][c])
					cells[r][c] = (counts[r][c] >= lgs_pkg::LIVE_LOW &&
					               counts[r][c] <= lgs_pkg::LIVE_HIGH);
				else
					cells[r][c] = (counts[r][c] == lgs_pkg::LIVE_HIGH);
	endfunction

	function void note_word(logic [1:0] f, logic [5:0] c, logic [5:0] r);
		life_result_t res;
		int uw;
		int uh;
		res = '0;
		uw  = used(width_reg, lgs_pkg::MAX_WIDTH_DEF);
		uh  = used(height_reg, lgs_pkg::MAX_HEIGHT_DEF);
		if (f == lgs_pkg::FUNC_SET || f == lgs_pkg::FUNC_QUERY) begin
			if (c >= uw || r >= uh)
				res.out_of_range = 1'b1;
			else if (f == lgs_pkg::FUNC_SET)
				cells[r][c] = 1'b1;
			else
				res.cell_alive = cells[r][c];
		end else if (f == lgs_pkg::FUNC_STEP) begin
			advance_generation();
		end
		pending_q.push_back(res);
	endfunction

	function void flag(string what, life_result_t want, logic alive, logic oor);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch on %s: expected alive=%0b oor=%0b, got alive=%0b oor=%0b",
			         $time, what, want.cell_alive, want.out_of_range, alive, oor);
	endfunction

	function void check_word(logic alive, logic oor);
		life_result_t want;
		if (pending_q.size() == 0) begin
			flag("response with none pending", 'x, alive, oor);
			return;
		end
		want = pending_q.pop_front();
		checked++;
		if (alive !== want.cell_alive)
			flag("cell_alive", want, alive, oor);
		if (oor !== want.out_of_range)
			flag("out_of_range", want, alive, oor);
	endfunction
endclass

module life_grid_generation_step_top_test;

	localparam logic [lgs_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lgs_pkg::CFG_W-1:0]     cfg_wdata;

	lgs_req_if req_if();
	lgs_rsp_if rsp_if();

	life_scoreboard sb = new();
	bit             calm;
	int             words_sent;
	int             steps_sent;

	life_grid_generation_step_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d responses still pending", sb.pending_q.size());
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int draw_wait();
		if (calm)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// response side: random stall before each word
	initial begin : rsp_sink
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
			sb.check_word(rsp_if.cell_alive, rsp_if.out_of_range);
		end
	end

	// valid stays high across back-to-back words; lowered when a gap is drawn or in drain_words
	task automatic send_word(input logic [lgs_pkg::FUNC_W-1:0] f,
	                         input logic [lgs_pkg::COORD_W-1:0] c,
	                         input logic [lgs_pkg::COORD_W-1:0] r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func  <= f;
		req_if.col   <= c;
		req_if.row   <= r;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sb.note_word(f, c, r);
		words_sent++;
		if (f == lgs_pkg::FUNC_STEP)
			steps_sent++;
	endtask

	task automatic drain_words();
		req_if.valid <= 1'b0;
		while (sb.pending_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_grid(input logic [lgs_pkg::CFG_W-1:0] w,
	                        input logic [lgs_pkg::CFG_W-1:0] h);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= lgs_pkg::REG_GRID_WIDTH;
		cfg_wdata <= w;
		sb.write_reg(lgs_pkg::REG_GRID_WIDTH, w);
		@(posedge clk);
		cfg_index <= lgs_pkg::REG_GRID_HEIGHT;
		cfg_wdata <= h;
		sb.write_reg(lgs_pkg::REG_GRID_HEIGHT, h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int                          uw;
		int                          uh;
		int                          ww;
		int                          wh;
		int                          ox;
		int                          oy;
		int                          pick;
		int                          pos;
		logic [lgs_pkg::CFG_W-1:0]   gw;
		logic [lgs_pkg::CFG_W-1:0]   gh;
		logic [lgs_pkg::FUNC_W-1:0]  f;
		logic [lgs_pkg::COORD_W-1:0] c;
		logic [lgs_pkg::COORD_W-1:0] r;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = lgs_pkg::REG_GRID_WIDTH;
		cfg_wdata    = '0;
		req_if.valid = 1'b0;
		req_if.func  = lgs_pkg::FUNC_SET;
		req_if.col   = '0;
		req_if.row   = '0;
		calm         = 1'b0;
		words_sent   = 0;
		steps_sent   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// full 64x64 grid from reset: corners, repeat set, unused code
		send_word(lgs_pkg::FUNC_SET, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_SET, 6'd63, 6'd63);
		send_word(lgs_pkg::FUNC_QUERY, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_QUERY, 6'd63, 6'd63);
		send_word(lgs_pkg::FUNC_QUERY, 6'd62, 6'd63);
		send_word(lgs_pkg::FUNC_SET, 6'd0, 6'd0);
		send_word(FUNC_UNUSED, 6'd63, 6'd63);
		// blinker, row 20
		send_word(lgs_pkg::FUNC_SET, 6'd10, 6'd20);
		send_word(lgs_pkg::FUNC_SET, 6'd11, 6'd20);
		send_word(lgs_pkg::FUNC_SET, 6'd12, 6'd20);
		send_word(lgs_pkg::FUNC_STEP, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_QUERY, 6'd11, 6'd19);
		send_word(lgs_pkg::FUNC_QUERY, 6'd11, 6'd21);
		send_word(lgs_pkg::FUNC_QUERY, 6'd10, 6'd20);
		send_word(lgs_pkg::FUNC_QUERY, 6'd0, 6'd0);
		drain_words();

		// empty grid: everything out of range, step is a no-op
		set_grid(7'd0, 7'd0);
		send_word(lgs_pkg::FUNC_SET, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_QUERY, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_STEP, 6'd0, 6'd0);
		drain_words();

		// oversize saturates to the full grid
		set_grid(7'd127, 7'd127);
		send_word(lgs_pkg::FUNC_QUERY, 6'd11, 6'd20);
		send_word(lgs_pkg::FUNC_STEP, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_QUERY, 6'd10, 6'd20);
		drain_words();

		// shrink past the blinker, then grow back: hidden cells must survive
		set_grid(7'd12, 7'd21);
		send_word(lgs_pkg::FUNC_QUERY, 6'd12, 6'd20);
		send_word(lgs_pkg::FUNC_STEP, 6'd0, 6'd0);
		send_word(lgs_pkg::FUNC_QUERY, 6'd11, 6'd20);
		drain_words();
		set_grid(7'd64, 7'd64);
		send_word(lgs_pkg::FUNC_QUERY, 6'd12, 6'd20);

		for (int p = 0; p < 10; p++) begin
			drain_words();
			case (p)
				0: begin gw = 7'd5;   gh = 7'd4;   end
				1: begin gw = 7'd8;   gh = 7'd8;   end
				2: begin gw = 7'd1;   gh = 7'd1;   end
				3: begin gw = 7'd3;   gh = 7'd127; end
				4: begin gw = 7'd64;  gh = 7'd64;  end
				5: begin gw = 7'd65;  gh = 7'd2;   end
				6: begin gw = 7'd0;   gh = 7'd7;   end
				7: begin gw = 7'd16;  gh = 7'd3;   end
				8: begin gw = 7'd2;   gh = 7'd64;  end
				default: begin gw = 7'd127; gh = 7'd10; end
			endcase
			set_grid(gw, gh);
			calm = (p % 3 == 1);
			uw   = sb.used(gw, lgs_pkg::MAX_WIDTH_DEF);
			uh   = sb.used(gh, lgs_pkg::MAX_HEIGHT_DEF);
			// seed patterns into a small window so steps have something to evolve
			ww   = (uw > 8) ? 8 : uw;
			wh   = (uh > 8) ? 8 : uh;
			ox   = (uw > 8) ? $urandom_range(0, uw - 8) : 0;
			oy   = (uh > 8) ? $urandom_range(0, uh - 8) : 0;
			for (int i = 0; i < 12; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					f = lgs_pkg::FUNC_SET;
				else if (pick < 75)
					f = lgs_pkg::FUNC_QUERY;
				else if (pick < 95)
					f = lgs_pkg::FUNC_STEP;
				else
					f = FUNC_UNUSED;
				if (uw > 0 && uh > 0 && $urandom_range(0, 4) != 0) begin
					pos = ox + $urandom_range(0, ww - 1);
					c   = pos[lgs_pkg::COORD_W-1:0];
					pos = oy + $urandom_range(0, wh - 1);
					r   = pos[lgs_pkg::COORD_W-1:0];
				end else begin
					pos = $urandom_range(0, 63);
					c   = pos[lgs_pkg::COORD_W-1:0];
					pos = $urandom_range(0, 63);
					r   = pos[lgs_pkg::COORD_W-1:0];
				end
				send_word(f, c, r);
				// hold the sender until every response is back
				if (p == 3 && i == 6)
					drain_words();
			end
		end

		drain_words();
		repeat (80) @(posedge clk);
		$display("covered %0d words, %0d generation steps, %0d responses checked, %0d errors",
		         words_sent, steps_sent, sb.checked, sb.errors);
		$display("grid sizes ranged over empty, 1x1, odd shapes, full and saturated settings");
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
